[src/uhid_pkg.sv]
// Package for the HID control request responder: types, codes and constants.
// Used by usb_hid_control_request_responder.
`default_nettype none
package uhid_pkg;
    localparam int DirEntries = 8;
    localparam int SlotW = 3;
    localparam int MaxPacket = 64;
    localparam int MaxRes = 4;

    localparam logic [1:0] ACT_BUS_RESET = 2'd0;
    localparam logic [1:0] ACT_SETUP     = 2'd1;
    localparam logic [1:0] ACT_LOAD      = 2'd2;
    localparam logic [1:0] ACT_IGNORED   = 2'd3;

    localparam logic [1:0] KIND_STALL  = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_MEMORY = 2'd2;
    localparam logic [1:0] KIND_INLINE = 2'd3;

    localparam logic [7:0] REQ_GET_STATUS   = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS  = 8'h05;
    localparam logic [7:0] REQ_GET_DESC     = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG   = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG   = 8'h09;
    localparam logic [7:0] CLS_GET_REPORT   = 8'h01;
    localparam logic [7:0] CLS_GET_IDLE     = 8'h02;
    localparam logic [7:0] CLS_GET_PROTOCOL = 8'h03;
    localparam logic [7:0] CLS_SET_REPORT   = 8'h09;
    localparam logic [7:0] CLS_SET_IDLE     = 8'h0A;
    localparam logic [7:0] CLS_SET_PROTOCOL = 8'h0B;

    localparam logic [63:0] FIXED_REPORT = 64'h0000_0000_0701_2621;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CHECK, ST_EMIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]  desc_len;
        logic [15:0] mem_start;
        logic [15:0] key_index;
        logic [15:0] key_value;
    } t_entry;
endpackage
`default_nettype wire

[src/usb_hid_control_request_responder.sv]
// Top level of the HID control request responder: setup decode, directory
// search over a synchronous memory, and packet generation. Uses uhid_pkg.
`default_nettype none
//  channel  direction  fields
//  s_axis   in         tuser: action; tdata: setup type, request_code, value,
//                      index, length, entry_slot, entry_address, entry_length
//  m_axis   out        tuser: kind; tdata: memory_address..endpoints_reset;
//                      tlast: last
//  cfg      in         index 0 mode flag, index 1 directory count
// A setup request reads and compares each directory entry searched (read,
// compare) and then stages and presents each result packet (stage, present);
// other requests present their one result the cycle after the transfer.
// Bus reset and loads need no further states. Reset restores the request state;
// the directory is undefined until loaded. A stalled output holds the packet.
module usb_hid_control_request_responder
    import uhid_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [3:0]   i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // setup type[7:0], request_code[15:8], value[31:16], index[47:32],
    // length[63:48], entry_slot[66:64], entry_address[82:67],
    // entry_length[90:83], zero fill to 96
    input  wire logic [95:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // response_kind[1:0]
    output logic [1:0]        m_axis_tuser,
    // memory_address[15:0], byte_count[22:16], inline_bytes[86:23],
    // inline_count[90:87], device_address[97:91], address_enabled[98],
    // configuration_value[106:99], endpoints_reset[107], zero fill to 112
    output logic [111:0]      m_axis_tdata,
    output logic              m_axis_tlast
);
    t_state r_state, n_state;
    logic        r_mode;
    logic [3:0]  r_count;
    logic [7:0]  r_config, r_idle, r_proto;
    logic [6:0]  r_addr;
    logic        r_addr_en;
    t_entry      r_mem [DirEntries];
    t_entry      r_rd;
    logic [SlotW:0] r_i;
    logic [15:0] r_val, r_idx, r_hlen;
    logic [15:0] r_pa;
    logic [7:0]  r_left;
    logic [2:0]  r_k;
    logic [1:0]  r_kind;
    logic [6:0]  r_cnt;
    logic [63:0] r_ib;
    logic [3:0]  r_ic;
    logic        r_epr, r_last;

    wire logic [1:0]  in_act  = s_axis_tuser;
    wire logic [7:0]  in_rt   = s_axis_tdata[7:0];
    wire logic [7:0]  in_code = s_axis_tdata[15:8];
    wire logic [15:0] in_val  = s_axis_tdata[31:16];
    wire logic [15:0] in_idx  = s_axis_tdata[47:32];
    wire logic [15:0] in_len  = s_axis_tdata[63:48];
    wire logic [2:0]  in_slot = s_axis_tdata[66:64];
    wire logic [15:0] in_ea   = s_axis_tdata[82:67];
    wire logic [7:0]  in_el   = s_axis_tdata[90:83];

    logic acc, out_fire;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign out_fire = m_axis_tvalid && m_axis_tready;

    logic [SlotW:0] lim;
    assign lim = (r_count > 4'(DirEntries)) ? (SlotW+1)'(DirEntries) : r_count[SlotW:0];

    // Directory memory: one write port for loads, one registered read.
    always_ff @(posedge i_clk) begin
        if (acc && in_act == ACT_LOAD) begin
            r_mem[in_slot] <= '{in_el, in_ea, in_idx, in_val};
        end
        r_rd <= r_mem[r_i[SlotW-1:0]];
    end

    logic hit;
    assign hit = (r_rd.key_value == r_val) && (r_rd.key_index == r_idx);
    logic [7:0] hcap, tlen, n_bytes;
    assign hcap = (r_hlen > 16'd255) ? 8'd255 : r_hlen[7:0];
    assign tlen = (hcap > r_rd.desc_len) ? r_rd.desc_len : hcap;
    assign n_bytes = (r_left > 8'(MaxPacket)) ? 8'(MaxPacket) : r_left;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && in_act == ACT_SETUP) begin
                    n_state = (in_rt[6:5] == 2'd0 && in_code == REQ_GET_DESC && lim != '0)
                              ? ST_READ : ST_OUT;
                end
            end
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: begin
                priority if (hit) n_state = ST_EMIT;
                else if (r_i + 1'b1 >= lim) n_state = ST_OUT;
                else n_state = ST_READ;
            end
            ST_EMIT:  n_state = ST_OUT;
            ST_OUT:   if (out_fire) n_state = r_last ? ST_IDLE : ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_mode <= 1'b0; r_count <= '0;
            r_config <= '0; r_idle <= '0; r_proto <= 8'd1;
            r_addr <= '0; r_addr_en <= 1'b0; r_i <= '0; r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) r_mode <= i_cfg_data[0];
                else r_count <= i_cfg_data;
            end
            if (acc && in_act == ACT_BUS_RESET) r_config <= '0;
            if (acc && in_act == ACT_SETUP) begin
                r_val <= in_val; r_idx <= in_idx; r_hlen <= in_len;
                r_i <= '0; r_k <= '0;
                r_kind <= KIND_STALL; r_cnt <= '0; r_ib <= '0; r_ic <= '0;
                r_pa <= '0; r_epr <= 1'b0; r_last <= 1'b1;
                if (in_rt[6:5] == 2'd0) begin
                    priority if (in_code == REQ_GET_DESC) begin
                        // The search follows; a miss keeps the staged stall result.
                    end else if (in_code == REQ_SET_CONFIG && !in_rt[7]
                                 && in_rt[4:0] == 5'd0) begin
                        r_config <= in_val[7:0]; r_kind <= KIND_STATUS; r_epr <= 1'b1;
                    end else if (in_code == REQ_SET_ADDRESS) begin
                        r_addr <= in_val[6:0]; r_addr_en <= 1'b1;
                        r_kind <= KIND_STATUS;
                    end else if (in_code == REQ_GET_CONFIG && in_rt[7]
                                 && in_rt[4:0] == 5'd0) begin
                        r_kind <= KIND_INLINE; r_ib <= {56'd0, r_config}; r_ic <= 4'd1;
                    end else if (in_code == REQ_GET_STATUS) begin
                        r_kind <= KIND_INLINE; r_ic <= 4'd2;
                    end else begin
                    end
                end else if (in_rt[6:5] == 2'd1) begin
                    if (in_rt[7]) begin
                        priority if (in_code == CLS_GET_REPORT && r_mode) begin
                            r_kind <= KIND_INLINE; r_ib <= FIXED_REPORT; r_ic <= 4'd8;
                        end else if (in_code == CLS_GET_IDLE) begin
                            r_kind <= KIND_INLINE; r_ib <= {56'd0, r_idle}; r_ic <= 4'd1;
                        end else if (in_code == CLS_GET_PROTOCOL) begin
                            r_kind <= KIND_INLINE; r_ib <= {56'd0, r_proto}; r_ic <= 4'd1;
                        end else begin
                        end
                    end else begin
                        priority if (in_code == CLS_SET_REPORT) begin
                            r_kind <= KIND_STATUS;
                        end else if (in_code == CLS_SET_IDLE) begin
                            r_idle <= in_val[15:8]; r_kind <= KIND_STATUS;
                        end else if (in_code == CLS_SET_PROTOCOL) begin
                            r_proto <= in_val[7:0]; r_kind <= KIND_STATUS;
                        end else begin
                        end
                    end
                end
            end
            if (r_state == ST_CHECK) begin
                if (hit) begin
                    r_pa <= r_rd.mem_start; r_left <= tlen;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            if (r_state == ST_EMIT) begin
                r_kind <= KIND_MEMORY;
                r_cnt <= n_bytes[6:0];
                r_left <= r_left - n_bytes;
                r_k <= r_k + 3'd1;
                r_last <= !(((r_left != n_bytes) || (n_bytes == 8'(MaxPacket)))
                            && (r_k + 3'd1 < 3'(MaxRes)));
            end
            if (out_fire && !r_last) r_pa <= r_pa + 16'(r_cnt);
        end
    end

    assign m_axis_tdata = {4'b0000, r_epr, r_config, r_addr_en, r_addr, r_ic, r_ib,
                           r_cnt, r_pa};
    assign m_axis_tuser = r_kind;
    assign m_axis_tlast = r_last;

`ifndef SYNTHESIS
    a_tready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("accepting while output busy");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_cnt <= 7'(MaxPacket)) else $error("packet too long");
    a_pkt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_k == 3'(MaxRes) |-> m_axis_tlast) else $error("too many packets");
    a_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK |-> r_i < lim) else $error("search past directory");
`endif
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for usb_hid_control_request_responder: drives setup,
// load and bus-reset transfers and checks every response packet against a
// behavioral predictor. Depends on uhid_pkg and the responder RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import uhid_pkg::*;

    // Declared from the highest bits down, so the last field sits lowest.
    typedef struct packed {
        logic [7:0]  elen;
        logic [15:0] addr;
        logic [2:0]  slot;
        logic [15:0] length;
        logic [15:0] index;
        logic [15:0] value;
        logic [7:0]  req_code;
        logic [7:0]  req_type;
        logic [1:0]  action;
    } t_item;

    typedef struct packed {
        logic        last;
        logic        ep_reset;
        logic [7:0]  cfg_val;
        logic        addr_en;
        logic [6:0]  dev_addr;
        logic [3:0]  icount;
        logic [63:0] ibytes;
        logic [6:0]  bcount;
        logic [15:0] maddr;
        logic [1:0]  kind;
    } t_packet;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [3:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // action
    logic [1:0]   s_axis_tuser;
    // setup type, request_code, value, index, length, entry_slot,
    // entry_address, entry_length
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // response_kind
    logic [1:0]   m_axis_tuser;
    // memory_address, byte_count, inline_bytes, inline_count, device_address,
    // address_enabled, configuration_value, endpoints_reset
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;

    usb_hid_control_request_responder u_top (.*);

    // Predictor state.
    logic        mode_flag;
    logic [3:0]  dir_count;
    logic [7:0]  cfg_reg, idle_reg, proto_reg;
    logic [6:0]  addr_reg;
    logic        addr_valid;
    t_entry      dir_mem [DirEntries];

    t_item   pending_items[$];
    t_packet expected_packets[$];
    int      errors;
    int      send_wait, recv_wait;
    logic    hold_sender;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic t_packet make_packet(input logic [1:0] kind, input logic [15:0] maddr,
                                            input logic [6:0] bc, input logic [63:0] ib,
                                            input logic [3:0] ic, input logic epr);
        t_packet p;
        p.kind = kind; p.maddr = maddr; p.bcount = bc; p.ibytes = ib; p.icount = ic;
        p.dev_addr = addr_reg; p.addr_en = addr_valid; p.cfg_val = cfg_reg;
        p.ep_reset = epr; p.last = 1'b1;
        return p;
    endfunction

    task automatic predict_descriptor(input t_item it);
        int lim, hit, len, n, k;
        logic [15:0] a;
        t_packet p;
        lim = (dir_count > DirEntries) ? DirEntries : dir_count;
        hit = -1;
        for (int i = 0; i < lim; i++)
            if (hit < 0 && dir_mem[i].key_value == it.value && dir_mem[i].key_index == it.index)
                hit = i;
        if (hit < 0) begin
            expected_packets.push_back(make_packet(KIND_STALL, 0, 0, 0, 0, 0));
            return;
        end
        len = (it.length < 256) ? it.length : 255;
        if (len > dir_mem[hit].desc_len) len = dir_mem[hit].desc_len;
        a = dir_mem[hit].mem_start;
        k = 0;
        do begin
            n = (len < MaxPacket) ? len : MaxPacket;
            p = make_packet(KIND_MEMORY, a, n[6:0], 0, 0, 0);
            a = a + n[15:0];
            len -= n;
            k++;
            p.last = !((len != 0 || n == MaxPacket) && k < MaxRes);
            expected_packets.push_back(p);
        end while (!p.last);
    endtask

    task automatic predict_request(input t_item it);
        logic [1:0] rkind;
        logic dir_in, to_dev;
        rkind = it.req_type[6:5];
        dir_in = it.req_type[7];
        to_dev = it.req_type[4:0] == 5'd0;
        if (rkind == 2'd0) begin
            if (it.req_code == REQ_GET_DESC) begin
                predict_descriptor(it);
                return;
            end
            if (it.req_code == REQ_SET_CONFIG && !dir_in && to_dev) begin
                cfg_reg = it.value[7:0];
                expected_packets.push_back(make_packet(KIND_STATUS, 0, 0, 0, 0, 1));
                return;
            end
            if (it.req_code == REQ_SET_ADDRESS) begin
                addr_reg = it.value[6:0];
                addr_valid = 1'b1;
                expected_packets.push_back(make_packet(KIND_STATUS, 0, 0, 0, 0, 0));
                return;
            end
            if (it.req_code == REQ_GET_CONFIG && dir_in && to_dev) begin
                expected_packets.push_back(make_packet(KIND_INLINE, 0, 0, {56'd0, cfg_reg}, 1, 0));
                return;
            end
            if (it.req_code == REQ_GET_STATUS) begin
                expected_packets.push_back(make_packet(KIND_INLINE, 0, 0, 0, 2, 0));
                return;
            end
        end
        if (rkind == 2'd1) begin
            if (dir_in) begin
                if (it.req_code == CLS_GET_REPORT && mode_flag) begin
                    expected_packets.push_back(make_packet(KIND_INLINE, 0, 0, FIXED_REPORT, 8, 0));
                    return;
                end
                if (it.req_code == CLS_GET_IDLE) begin
                    expected_packets.push_back(
                        make_packet(KIND_INLINE, 0, 0, {56'd0, idle_reg}, 1, 0));
                    return;
                end
                if (it.req_code == CLS_GET_PROTOCOL) begin
                    expected_packets.push_back(
                        make_packet(KIND_INLINE, 0, 0, {56'd0, proto_reg}, 1, 0));
                    return;
                end
            end else begin
                if (it.req_code == CLS_SET_REPORT) begin
                    expected_packets.push_back(make_packet(KIND_STATUS, 0, 0, 0, 0, 0));
                    return;
                end
                if (it.req_code == CLS_SET_IDLE) begin
                    idle_reg = it.value[15:8];
                    expected_packets.push_back(make_packet(KIND_STATUS, 0, 0, 0, 0, 0));
                    return;
                end
                if (it.req_code == CLS_SET_PROTOCOL) begin
                    proto_reg = it.value[7:0];
                    expected_packets.push_back(make_packet(KIND_STATUS, 0, 0, 0, 0, 0));
                    return;
                end
            end
        end
        expected_packets.push_back(make_packet(KIND_STALL, 0, 0, 0, 0, 0));
    endtask

    task automatic predict_transfer(input t_item it);
        case (it.action)
            ACT_BUS_RESET: cfg_reg = 8'd0;
            ACT_SETUP:     predict_request(it);
            ACT_LOAD: begin
                dir_mem[it.slot] = '{desc_len: it.elen, mem_start: it.addr,
                                     key_index: it.index, key_value: it.value};
            end
            default: ;
        endcase
    endtask

    // Driver: one item at a time with a random gap before each.
    always @(posedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser <= '0;
            s_axis_tdata <= '0;
            send_wait <= $urandom_range(0, 9);
        end else if (s_axis_tvalid && s_axis_tready) begin
            predict_transfer({s_axis_tdata[90:0], s_axis_tuser});
            s_axis_tvalid <= 1'b0;
            send_wait <= $urandom_range(0, 9);
        end else if (!s_axis_tvalid && !hold_sender) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                s_axis_tuser <= nxt.action;
                s_axis_tdata <= {5'd0, nxt[92:2]};
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Monitor: random backpressure and comparison with the oldest expectation.
    always @(posedge i_clk) begin
        t_packet got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata[107:0], m_axis_tuser};
                if (expected_packets.size() == 0) begin
                    report_mismatch($sformatf("unexpected packet %h", got));
                end else begin
                    want = expected_packets.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
                    if (got.maddr != want.maddr)
                        report_mismatch($sformatf("address %h want %h", got.maddr, want.maddr));
                    if (got.bcount != want.bcount)
                        report_mismatch($sformatf("count %0d want %0d", got.bcount, want.bcount));
                    if (got.ibytes != want.ibytes)
                        report_mismatch($sformatf("inline %h want %h", got.ibytes, want.ibytes));
                    if (got.icount != want.icount)
                        report_mismatch($sformatf("inline count %0d want %0d",
                                                  got.icount, want.icount));
                    if (got.dev_addr != want.dev_addr)
                        report_mismatch($sformatf("device address %0d want %0d",
                                                  got.dev_addr, want.dev_addr));
                    if (got.addr_en != want.addr_en)
                        report_mismatch("address enable");
                    if (got.cfg_val != want.cfg_val)
                        report_mismatch($sformatf("configuration %0d want %0d",
                                                  got.cfg_val, want.cfg_val));
                    if (got.ep_reset != want.ep_reset)
                        report_mismatch("endpoints reset");
                    if (got.last != want.last)
                        report_mismatch("last flag");
                end
                recv_wait <= $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_item setup_item(input logic [7:0] rt, input logic [7:0] code,
                                         input logic [15:0] val, input logic [15:0] idx,
                                         input logic [15:0] len);
        t_item it;
        it = '{action: ACT_SETUP, req_type: rt, req_code: code, value: val, index: idx,
               length: len, slot: $urandom, addr: $urandom, elen: $urandom};
        return it;
    endfunction

    function automatic t_item load_item(input logic [2:0] s, input logic [15:0] val,
                                        input logic [15:0] idx, input logic [15:0] a,
                                        input logic [7:0] l);
        t_item it;
        it = '{action: ACT_LOAD, req_type: $urandom, req_code: $urandom, value: val,
               index: idx, length: $urandom, slot: s, addr: a, elen: l};
        return it;
    endfunction

    // Random setup; descriptor lookups only use keys of loaded slots or counts
    // that cover nothing unloaded.
    function automatic t_item random_item();
        t_item it;
        int r, s;
        logic [7:0] codes [12];
        codes = '{REQ_GET_STATUS, REQ_SET_ADDRESS, REQ_GET_DESC, REQ_GET_CONFIG,
                  REQ_SET_CONFIG, CLS_GET_REPORT, CLS_GET_IDLE, CLS_GET_PROTOCOL,
                  CLS_SET_IDLE, CLS_SET_PROTOCOL, REQ_GET_DESC, REQ_GET_DESC};
        r = $urandom_range(0, 99);
        s = $urandom_range(0, DirEntries - 1);
        it = setup_item($urandom, codes[$urandom_range(0, 11)], $urandom, $urandom,
                        $urandom);
        if (r < 8) it.action = ACT_BUS_RESET;
        else if (r < 10) it.action = ACT_IGNORED;
        else if (r < 18) it = load_item(s, $urandom, $urandom, $urandom, $urandom);
        else if (r < 25) it.req_code = $urandom;
        else begin
            if ($urandom_range(0, 2) != 0) it.req_type[6:5] = $urandom_range(0, 1);
            if ($urandom_range(0, 1)) it.req_type[4:0] = 5'd0;
            if (r < 60) begin
                it.req_code = REQ_GET_DESC;
                it.req_type[6:5] = 2'd0;
                it.value = dir_mem[s].key_value;
                it.index = dir_mem[s].key_index;
                if ($urandom_range(0, 3) == 0) it.index = $urandom;
                if ($urandom_range(0, 1)) it.length = $urandom_range(0, 300);
            end
        end
        return it;
    endfunction

    // Sends what is queued, then holds the sender and waits until every result is back.
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        hold_sender = 1'b1;
        while (expected_packets.size() > 0)
            @(posedge i_clk);
        repeat (2 * DirEntries + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MODE) mode_flag = data[0];
        else dir_count = data;
    endtask

    initial begin
        t_item it;
        errors = 0;
        hold_sender = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = 4'd0;
        mode_flag = 1'b0;
        dir_count = 4'd0;
        cfg_reg = 0; idle_reg = 0; proto_reg = 8'd1; addr_reg = 0; addr_valid = 0;
        for (int i = 0; i < DirEntries; i++) begin
            dir_mem[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no entries searched, every lookup misses.
        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'h0100, 0, 16'd18));
        pending_items.push_back(setup_item(8'hA1, CLS_GET_REPORT, 0, 0, 8));
        pending_items.push_back(setup_item(8'hA1, CLS_GET_PROTOCOL, 0, 0, 1));
        pending_items.push_back(load_item(0, 16'h0100, 0, 16'h0000, 8'd18));
        pending_items.push_back(load_item(1, 16'h0200, 0, 16'hFFF0, 8'd255));
        pending_items.push_back(load_item(2, 16'h2200, 16'h0000, 16'h1234, 8'd64));
        pending_items.push_back(load_item(3, 16'hFFFF, 16'hFFFF, 16'h0040, 8'd0));
        pending_items.push_back(load_item(4, 16'h0300, 16'h0409, 16'h8000, 8'd128));
        pending_items.push_back(load_item(5, 16'h0301, 16'h0409, 16'h0100, 8'd63));
        pending_items.push_back(load_item(6, 16'h0302, 16'h0409, 16'h0200, 8'd1));
        pending_items.push_back(load_item(7, 16'h0000, 16'h0000, 16'hFFFF, 8'd200));
        for (int i = 0; i < 25; i++) pending_items.push_back(random_item());
        hold_sender = 1'b0;
        wait_drained();
        write_reg(CFG_MODE, 4'd1);
        write_reg(CFG_COUNT, 4'd8);
        hold_sender = 1'b0;

        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'h0200, 0, 16'hFFFF));
        pending_items.push_back(setup_item(8'h00, REQ_GET_DESC, 16'h2200, 0, 16'd64));
        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'hFFFF, 16'hFFFF, 16'd9));
        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'h0300, 16'h0409, 16'd0));
        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'h0300, 16'h0409, 16'd128));
        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'h0000, 0, 16'd255));
        pending_items.push_back(setup_item(8'h80, REQ_GET_DESC, 16'h0555, 0, 16'd8));
        pending_items.push_back(setup_item(8'h1F, REQ_SET_ADDRESS, 16'hFFFF, 0, 0));
        pending_items.push_back(setup_item(8'h00, REQ_SET_CONFIG, 16'h00FF, 0, 0));
        pending_items.push_back(setup_item(8'h80, REQ_SET_CONFIG, 16'h0001, 0, 0));
        pending_items.push_back(setup_item(8'h80, REQ_GET_CONFIG, 0, 0, 1));
        pending_items.push_back(setup_item(8'h81, REQ_GET_CONFIG, 0, 0, 1));
        pending_items.push_back(setup_item(8'hFF, REQ_GET_STATUS, 0, 0, 2));
        pending_items.push_back(setup_item(8'h21, CLS_SET_IDLE, 16'hFF00, 0, 0));
        pending_items.push_back(setup_item(8'hA1, CLS_GET_IDLE, 0, 0, 1));
        pending_items.push_back(setup_item(8'h21, CLS_SET_PROTOCOL, 16'h00FF, 0, 0));
        pending_items.push_back(setup_item(8'hA1, CLS_GET_PROTOCOL, 0, 0, 1));
        pending_items.push_back(setup_item(8'h21, CLS_SET_REPORT, 0, 0, 8));
        pending_items.push_back(setup_item(8'hA1, CLS_GET_REPORT, 0, 0, 8));
        pending_items.push_back(setup_item(8'hC0, 8'hFF, 0, 0, 0));
        it = setup_item(0, 0, 0, 0, 0);
        it.action = ACT_BUS_RESET;
        pending_items.push_back(it);
        pending_items.push_back(setup_item(8'h80, REQ_GET_CONFIG, 0, 0, 1));
        it.action = ACT_IGNORED;
        pending_items.push_back(it);

        // Random phases across register settings.
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            write_reg(CFG_MODE, 4'($urandom_range(0, 1)));
            write_reg(CFG_COUNT, (ph == 4) ? 4'd15 :
                                 ((ph == 0) ? 4'd0 : 4'($urandom_range(1, 8))));
            hold_sender = 1'b0;
            for (int i = 0; i < 60; i++) begin
                while (pending_items.size() > 4) @(posedge i_clk);
                pending_items.push_back(random_item());
            end
        end
        wait_drained();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
